FILE: rtl/sensor_frame_sync_checksum_parser_assert.svh
// assertion macros used by the checker file
`ifndef SENSOR_FRAME_SYNC_CHECKSUM_PARSER_ASSERT_SVH
`define SENSOR_FRAME_SYNC_CHECKSUM_PARSER_ASSERT_SVH

// same-cycle implication, idle during reset
`define SFSC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sfsc assertion failed");

// next-cycle implication, idle during reset
`define SFSC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sfsc assertion failed");

// same-cycle implication, also checked around reset
`define SFSC_ASSERT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("sfsc assertion failed");

`endif

FILE: rtl/sfsc_pkg.sv
// shared types and constants of the frame parser
package sfsc_pkg;

  // frame header byte
  localparam logic [7:0] HEADER_BYTE = 8'h57;

  // frame bytes that results read: positions FIRST_KEPT to LAST_KEPT
  localparam int FIRST_KEPT = 3;
  localparam int LAST_KEPT  = 13;
  localparam int NUM_KEPT   = LAST_KEPT - FIRST_KEPT + 1;

  // one input item
  typedef struct packed {
    logic [7:0]  rx_byte;
    logic [63:0] now_us;
  } in_item_t;

  // one result item
  typedef struct packed {
    logic [7:0]         sensor_id;
    logic [31:0]        sensor_time_ms;
    logic signed [23:0] distance_mm;
    logic [7:0]         range_status;
    logic [15:0]        echo_level;
    logic [63:0]        header_time_us;
  } res_t;

endpackage

FILE: rtl/sensor_frame_sync_checksum_parser.sv
// top level of the sum-checksum sensor frame parser
//
//   channel | direction | handshake            | fields
//   in      | input     | in_valid / in_stall  | in_rx_byte, in_now_us
//   out     | output    | out_valid / out_stall| sensor id, times, distance, status, strength
//
// one byte item per cycle unless in_stall is high; a frame's last byte is accepted into
// the input register, checked there, and its result is then loaded into the result register
// synchronous active-low reset returns the parser to header search
// in_stall rises only while a good-frame result waits behind a stalled output
module sensor_frame_sync_checksum_parser #(
  parameter int FRAME_LENGTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  input  logic [63:0]        in_now_us,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_sensor_id,
  output logic [31:0]        out_sensor_time_ms,
  output logic signed [23:0] out_distance_mm,
  output logic [7:0]         out_range_status,
  output logic [15:0]        out_echo_level,
  output logic [63:0]        out_header_time_us
);

  sfsc_pkg::in_item_t item;
  sfsc_pkg::res_t     res;
  sfsc_pkg::res_t     res_q;
  logic               item_valid;
  logic               take;
  logic               hit;
  logic               o_ready;

  // consume the held item unless its result has nowhere to go
  assign take = item_valid && (!hit || o_ready);

  sfsc_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .in_now_us  (in_now_us),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  sfsc_frame_asm #(
    .FRAME_LENGTH (FRAME_LENGTH)
  ) u_asm (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .hit        (hit),
    .res        (res)
  );

  sfsc_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (take && hit),
    .res_in    (res),
    .ready     (o_ready),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .res_out   (res_q)
  );

  // result fields to ports
  assign out_sensor_id      = res_q.sensor_id;
  assign out_sensor_time_ms = res_q.sensor_time_ms;
  assign out_distance_mm    = res_q.distance_mm;
  assign out_range_status   = res_q.range_status;
  assign out_echo_level     = res_q.echo_level;
  assign out_header_time_us = res_q.header_time_us;

endmodule

FILE: rtl/sfsc_in_stage.sv
// input register stage of the frame parser
module sfsc_in_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_rx_byte,
  input  logic [63:0]      in_now_us,
  input  logic             take,
  output logic             item_valid,
  output sfsc_pkg::in_item_t item
);

  logic               valid_r;
  logic               valid_nxt;
  sfsc_pkg::in_item_t item_r;
  logic               load;

  // hold the item while the parser cannot consume it
  assign in_stall = valid_r && !take;
  assign load     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (load) begin
      item_r.rx_byte <= in_rx_byte;
      item_r.now_us  <= in_now_us;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

FILE: rtl/sfsc_frame_asm.sv
// frame assembly, running checksum and result formation
module sfsc_frame_asm #(
  parameter int FRAME_LENGTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               item_valid,
  input  sfsc_pkg::in_item_t item,
  input  logic               take,
  output logic               hit,
  output sfsc_pkg::res_t     res
);

  localparam int POS_W = $clog2(FRAME_LENGTH);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LENGTH - 1);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [63:0]      start_r;
  logic             start_load;
  logic [7:0]       kept_r [sfsc_pkg::NUM_KEPT];

  // position and checksum update for the item being consumed
  always_comb begin
    pos_nxt    = pos_r;
    sum_nxt    = sum_r;
    start_load = 1'b0;
    if (take) begin
      if (pos_r == '0) begin
        if (item.rx_byte == sfsc_pkg::HEADER_BYTE) begin
          pos_nxt    = POS_W'(1);
          sum_nxt    = item.rx_byte;
          start_load = 1'b1;
        end
      end else if (pos_r < LAST_POS) begin
        pos_nxt = pos_r + POS_W'(1);
        sum_nxt = sum_r + item.rx_byte;
      end else begin
        pos_nxt = '0;
      end
    end
  end

  // a good frame ends on a byte equal to the running sum
  assign hit = item_valid && (pos_r == LAST_POS) && (sum_r == item.rx_byte);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      sum_r   <= '0;
      start_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      sum_r <= sum_nxt;
      if (start_load) begin
        start_r <= item.now_us;
      end
    end
  end

  // keep only the frame bytes that a result reads, each at its own position
  always_ff @(posedge clk) begin
    for (int k = 0; k < sfsc_pkg::NUM_KEPT; k++) begin
      if (take && pos_r == POS_W'(sfsc_pkg::FIRST_KEPT + k)) begin
        kept_r[k] <= item.rx_byte;
      end
    end
  end

  // result fields, little-endian
  always_comb begin
    res.sensor_id      = kept_r[0];
    res.sensor_time_ms = {kept_r[4], kept_r[3], kept_r[2], kept_r[1]};
    res.distance_mm    = $signed({kept_r[7], kept_r[6], kept_r[5]});
    res.range_status   = kept_r[8];
    res.echo_level     = {kept_r[10], kept_r[9]};
    res.header_time_us = start_r;
  end

endmodule

FILE: rtl/sfsc_out_reg.sv
// result register with stall handling
module sfsc_out_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  sfsc_pkg::res_t res_in,
  output logic           ready,
  input  logic           out_stall,
  output logic           out_valid,
  output sfsc_pkg::res_t res_out
);

  logic           valid_r;
  logic           valid_nxt;
  sfsc_pkg::res_t res_r;

  // free when empty or being taken this cycle
  assign ready = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign res_out   = res_r;

endmodule

FILE: rtl/sfsc_checker.sv
// port-level checker of the frame parser and its bind
`include "sensor_frame_sync_checksum_parser_assert.svh"

module sfsc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_sensor_id,
  input logic [63:0] out_header_time_us
);

  // a stalled result holds
  `SFSC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_sensor_id) && $stable(out_header_time_us))

  // input backpressure only comes from a blocked output
  `SFSC_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall)

  // reset empties both stages
  `SFSC_ASSERT_ALWAYS(a_reset_clear, $past(!rst_n), !out_valid && !in_stall)

endmodule

bind sensor_frame_sync_checksum_parser sfsc_checker u_sfsc_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_sensor_id      (out_sensor_id),
  .out_header_time_us (out_header_time_us)
);
